### design/lzs_pkg.sv
// Shared types, constants and the length code table of the LZS decompressor.
`timescale 1ns / 1ps
package lzs_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 2048;
  localparam int unsigned HS_W  = 12;   // history_size register width
  localparam int unsigned OFF_W = 11;   // match offset width
  localparam int unsigned BQ_W  = 32;   // bit queue width
  localparam logic [HS_W-1:0] HS_RESET = 12'd2048;

  // Input commands
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Token decode phases
  localparam logic [3:0] PH_TOKEN    = 4'd0;
  localparam logic [3:0] PH_LITERAL  = 4'd1;
  localparam logic [3:0] PH_OFFTYPE  = 4'd2;
  localparam logic [3:0] PH_SHORT    = 4'd3;
  localparam logic [3:0] PH_LONG     = 4'd4;
  localparam logic [3:0] PH_LENGTH   = 4'd5;
  localparam logic [3:0] PH_COPY     = 4'd6;
  localparam logic [3:0] PH_COPY_EXT = 4'd7;
  localparam logic [3:0] PH_EXTLEN   = 4'd8;

  localparam logic [3:0] EXT_CONT = 4'd15;   // extension nibble that continues
  localparam logic [3:0] LEN_EXT  = 4'd8;    // length that opens extensions

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } item_t;

  // Length code: upper nibble is the length, lower nibble the bits consumed.
  function automatic logic [7:0] len_code(input logic [3:0] top);
    logic [7:0] c;
    unique case (top)
      4'd0, 4'd1, 4'd2, 4'd3:   c = 8'h22;
      4'd4, 4'd5, 4'd6, 4'd7:   c = 8'h32;
      4'd8, 4'd9, 4'd10, 4'd11: c = 8'h42;
      4'd12:                    c = 8'h54;
      4'd13:                    c = 8'h64;
      4'd14:                    c = 8'h74;
      default:                  c = 8'h84;
    endcase
    return c;
  endfunction

endpackage

### design/lzs_if.sv
// Valid/ready stream interfaces for compressed words and decoded words.
`timescale 1ns / 1ps
interface lzs_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;
  modport source (output valid, output command, output in_byte, input ready);
  modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface lzs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       kind;
  logic       last;
  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

### design/lzs_front.sv
// Input side: accepts compressed words into a two-entry queue for the decoder.
`timescale 1ns / 1ps
module lzs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  lzs_in_if.sink            in_i,
  output logic              item_valid_o,
  output lzs_pkg::item_t    item_o,
  input  logic              item_pop_i
);
  import lzs_pkg::*;

  item_t      buf_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_i.ready   = (cnt_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign pop          = item_pop_i && item_valid_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rp_q];

  // Advance pointers and count
  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= '{command: in_i.command, in_byte: in_i.in_byte};
    end
  end

endmodule

### design/lzs_back.sv
// Decoder: bit queue, token sequencer, history ring and result staging.
`timescale 1ns / 1ps
module lzs_back #(
  parameter int unsigned HISTORY_DEPTH = lzs_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lzs_pkg::HS_W-1:0]  cfg_data_i,
  input  logic                      item_valid_i,
  input  lzs_pkg::item_t            item_i,
  output logic                      item_pop_o,
  lzs_out_if.source                 out_o
);
  import lzs_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_WR    = 4'd4;
  localparam logic [3:0] S_MODW  = 4'd5;
  localparam logic [3:0] S_MODO  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0]       state_q, state_d;
  logic [BQ_W-1:0]  bq_q, bq_d;
  logic [5:0]       fill_q, fill_d;
  logic [3:0]       phase_q, phase_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [3:0]       rem_q, rem_d;
  logic [AW-1:0]    wi_q, wi_d, ri_q, ri_d, clr_q, clr_d;
  logic [AW-1:0]    mod_q, mod_d, wmod_q, wmod_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [HS_W-1:0]  hs_q;
  logic             pend_v_q, pend_v_d, pend_k_q, pend_k_d;
  logic [7:0]       pend_b_q, pend_b_d;
  logic             ov_q, ov_d, ok_q, ok_d, ol_q, ol_d;
  logic [7:0]       ob_q, ob_d;

  logic [7:0]       mem [HISTORY_DEPTH];
  logic [7:0]       rd_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa;
  logic [7:0]       mem_wd;

  logic [AW:0]      ring;
  logic [AW:0]      wi_inc, ri_inc;
  logic [AW-1:0]    wi_nx, ri_nx;
  logic             can_push, emit_ok, do_emit, do_fin;
  logic [7:0]       e_byte;
  logic             e_kind;
  logic [7:0]       code;
  logic [5:0]       drop;
  logic [OFF_W-1:0] mod_x;
  logic             x_bit;
  logic [AW:0]      shifted, sub;

  // Effective ring size, clamped to 1..HISTORY_DEPTH
  always_comb begin
    if (hs_q == '0) begin
      ring = (AW+1)'(1);
    end else if (hs_q > HS_W'(HISTORY_DEPTH)) begin
      ring = (AW+1)'(HISTORY_DEPTH);
    end else begin
      ring = (AW+1)'(hs_q);
    end
  end

  assign wi_inc = {1'b0, wi_q} + (AW+1)'(1);
  assign ri_inc = {1'b0, ri_q} + (AW+1)'(1);
  assign wi_nx  = (wi_inc >= ring) ? '0 : wi_inc[AW-1:0];
  assign ri_nx  = (ri_inc >= ring) ? '0 : ri_inc[AW-1:0];

  assign can_push = !ov_q || out_o.ready;
  assign emit_ok  = !pend_v_q || can_push;
  assign code     = len_code(bq_q[BQ_W-1 -: 4]);
  assign drop     = 6'd7 + {3'd0, 3'(fill_q - 6'd7)};

  // One restoring remainder step, one operand bit per cycle
  assign mod_x   = (state_q == S_MODW) ? OFF_W'(wi_q) : off_q;
  assign x_bit   = mod_x[cnt_q];
  assign shifted = {mod_q, x_bit};
  assign sub     = (shifted >= ring) ? shifted - ring : shifted;

  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;

  // Sequence the decode
  always_comb begin
    state_d = state_q;
    bq_d    = bq_q;
    fill_d  = fill_q;
    phase_d = phase_q;
    off_d   = off_q;
    rem_d   = rem_q;
    wi_d    = wi_q;
    ri_d    = ri_q;
    clr_d   = clr_q;
    mod_d   = mod_q;
    wmod_d  = wmod_q;
    cnt_d   = cnt_q;
    mem_we  = 1'b0;
    mem_wa  = wi_q;
    mem_wd  = 8'd0;
    mem_re  = 1'b0;
    do_emit = 1'b0;
    do_fin  = 1'b0;
    e_byte  = 8'd0;
    e_kind  = KIND_DATA;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(HISTORY_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          if (item_i.command == CMD_RESTART) begin
            bq_d    = '0;
            fill_d  = '0;
            phase_d = PH_TOKEN;
            off_d   = '0;
            rem_d   = '0;
            wi_d    = '0;
            ri_d    = '0;
            clr_d   = '0;
            state_d = S_CLEAR;
          end else begin
            if (fill_q <= 6'd24) begin
              bq_d   = bq_q | (BQ_W'(item_i.in_byte) << (6'd24 - fill_q));
              fill_d = fill_q + 6'd8;
            end
            state_d = S_DEC;
          end
        end
      end
      S_DEC: begin
        unique case (phase_q)
          PH_TOKEN, PH_OFFTYPE: begin
            if (fill_q < 6'd1) begin
              state_d = S_FIN;
            end else begin
              bq_d   = bq_q << 1;
              fill_d = fill_q - 6'd1;
              if (phase_q == PH_TOKEN) begin
                phase_d = bq_q[BQ_W-1] ? PH_OFFTYPE : PH_LITERAL;
              end else begin
                phase_d = bq_q[BQ_W-1] ? PH_SHORT : PH_LONG;
              end
            end
          end
          PH_LITERAL: begin
            if (fill_q < 6'd8) begin
              state_d = S_FIN;
            end else if (emit_ok) begin
              do_emit = 1'b1;
              e_byte  = bq_q[BQ_W-1 -: 8];
              mem_we  = 1'b1;
              mem_wd  = bq_q[BQ_W-1 -: 8];
              wi_d    = wi_nx;
              bq_d    = bq_q << 8;
              fill_d  = fill_q - 6'd8;
              phase_d = PH_TOKEN;
            end
          end
          PH_SHORT: begin
            if (fill_q < 6'd7) begin
              state_d = S_FIN;
            end else if (bq_q[BQ_W-1 -: 7] != 7'd0) begin
              off_d   = OFF_W'(bq_q[BQ_W-1 -: 7]);
              bq_d    = bq_q << 7;
              fill_d  = fill_q - 6'd7;
              phase_d = PH_LENGTH;
            end else if (emit_ok) begin
              // End marker: drop to byte alignment
              do_emit = 1'b1;
              e_kind  = KIND_END;
              bq_d    = bq_q << drop;
              fill_d  = fill_q - drop;
              phase_d = PH_TOKEN;
            end
          end
          PH_LONG: begin
            if (fill_q < 6'd11) begin
              state_d = S_FIN;
            end else begin
              off_d   = bq_q[BQ_W-1 -: OFF_W];
              bq_d    = bq_q << 11;
              fill_d  = fill_q - 6'd11;
              phase_d = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            if (fill_q < {2'd0, code[3:0]}) begin
              state_d = S_FIN;
            end else begin
              bq_d    = bq_q << code[3:0];
              fill_d  = fill_q - {2'd0, code[3:0]};
              rem_d   = code[7:4];
              phase_d = (code[7:4] == LEN_EXT) ? PH_COPY_EXT : PH_COPY;
              mod_d   = '0;
              cnt_d   = 4'(OFF_W - 1);
              state_d = S_MODW;
            end
          end
          PH_COPY, PH_COPY_EXT: begin
            if (rem_q != 4'd0) begin
              state_d = S_RD;
            end else begin
              phase_d = (phase_q == PH_COPY) ? PH_TOKEN : PH_EXTLEN;
            end
          end
          PH_EXTLEN: begin
            if (fill_q < 6'd4) begin
              state_d = S_FIN;
            end else begin
              rem_d   = bq_q[BQ_W-1 -: 4];
              bq_d    = bq_q << 4;
              fill_d  = fill_q - 6'd4;
              phase_d = (bq_q[BQ_W-1 -: 4] == EXT_CONT) ? PH_COPY_EXT : PH_COPY;
            end
          end
          default: begin
            phase_d = PH_TOKEN;
          end
        endcase
      end
      S_MODW: begin
        mod_d = sub[AW-1:0];
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          wmod_d  = sub[AW-1:0];
          mod_d   = '0;
          cnt_d   = 4'(OFF_W - 1);
          state_d = S_MODO;
        end
      end
      S_MODO: begin
        mod_d = sub[AW-1:0];
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          if ({1'b0, wmod_q} >= sub) begin
            ri_d = AW'({1'b0, wmod_q} - sub);
          end else begin
            ri_d = AW'({1'b0, wmod_q} + ring - sub);
          end
          state_d = S_DEC;
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        ri_d    = ri_nx;
        state_d = S_WR;
      end
      S_WR: begin
        if (emit_ok) begin
          do_emit = 1'b1;
          e_byte  = rd_q;
          mem_we  = 1'b1;
          mem_wd  = rd_q;
          wi_d    = wi_nx;
          rem_d   = rem_q - 4'd1;
          state_d = S_DEC;
        end
      end
      S_FIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          do_fin  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Stage results: hold one back until it is known whether it ends the word
  always_comb begin
    ov_d     = ov_q && !out_o.ready;
    ob_d     = ob_q;
    ok_d     = ok_q;
    ol_d     = ol_q;
    pend_v_d = pend_v_q;
    pend_b_d = pend_b_q;
    pend_k_d = pend_k_q;
    if (do_emit) begin
      if (pend_v_q) begin
        ov_d = 1'b1;
        ob_d = pend_b_q;
        ok_d = pend_k_q;
        ol_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_b_d = e_byte;
      pend_k_d = e_kind;
    end else if (do_fin) begin
      ov_d     = 1'b1;
      ob_d     = pend_b_q;
      ok_d     = pend_k_q;
      ol_d     = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = ob_q;
  assign out_o.kind     = ok_q;
  assign out_o.last     = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      bq_q     <= '0;
      fill_q   <= '0;
      phase_q  <= PH_TOKEN;
      off_q    <= '0;
      rem_q    <= '0;
      wi_q     <= '0;
      ri_q     <= '0;
      clr_q    <= '0;
      cnt_q    <= '0;
      hs_q     <= HS_RESET;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      bq_q     <= bq_d;
      fill_q   <= fill_d;
      phase_q  <= phase_d;
      off_q    <= off_d;
      rem_q    <= rem_d;
      wi_q     <= wi_d;
      ri_q     <= ri_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      if (cfg_we_i) begin
        hs_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mod_q    <= mod_d;
    wmod_q   <= wmod_d;
    pend_b_q <= pend_b_d;
    pend_k_q <= pend_k_d;
    ob_q     <= ob_d;
    ok_q     <= ok_d;
    ol_q     <= ol_d;
  end

  // History ring
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[ri_q];
    end
  end

endmodule

### design/lzs_stream_decompressor.sv
// Top level of the LZS stream decompressor.
// Compressed words enter a two-entry queue and are decoded MSB first; each
// decoded word leaves on the output stream, the final one of each input word
// flagged last. A word is registered in the queue and taken in when the decoder
// is idle. It is then decoded in steps (token bit, offset type, offset, length
// code, literal, extension nibble, end of a copy), and a final step flags the
// last word. Every copied byte takes a decode step, a registered history read,
// then the write-back and emit. Each copy start passes through the bit-serial
// remainder unit that reduces the write index and offset to the ring size.
// Output stalls hold the decode. After reset and each restart the history ring
// is cleared one entry a cycle, during which no word is decoded (input words
// still queue and the register is still written).
`timescale 1ns / 1ps
module lzs_stream_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lzs_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  lzs_in_if.sink                   in_i,
  lzs_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [lzs_pkg::HS_W-1:0] cfg_data_i
);
  import lzs_pkg::*;

  item_t item;
  logic  item_valid, item_pop;

  lzs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  lzs_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

endmodule

### design/lzs_checker.sv
// Port-level checks for the LZS decompressor, bound to the top level.
`timescale 1ns / 1ps
module lzs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [7:0] out_byte_i,
  input logic out_kind_i,
  input logic out_last_i
);
  import lzs_pkg::*;

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_byte_i) && $stable(out_kind_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // End markers carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_END) |-> out_byte_i == 8'd0)
    else $error("end marker with nonzero byte");

  // Nothing is offered straight out of reset
  assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind lzs_stream_decompressor lzs_checker u_lzs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_kind_i  (out_o.kind),
  .out_last_i  (out_o.last)
);
